### hw/rtl/keyed_ordered_set_engine_macros.svh
// Assertion macros for the keyed ordered set engine checker.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef KEYED_ORDERED_SET_ENGINE_MACROS_SVH
`define KEYED_ORDERED_SET_ENGINE_MACROS_SVH

// Consequence checked in the same cycle as the antecedent.
`define KOSE_ASSERT_SAME(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("keyed ordered set engine: check failed");

// Consequence checked in the cycle after the antecedent.
`define KOSE_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("keyed ordered set engine: check failed");

`endif

### hw/rtl/kose_pkg.sv
// Shared constants, codes and structs of the keyed ordered set engine.
// No dependencies; the files that use it refer to it by scoped names.
package kose_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned KEY_BITS = 32;
  localparam int unsigned SLOT_W   = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned OP_W     = 3;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_ADD_BACK  = 3'd0,
    OP_ADD_FRONT = 3'd1,
    OP_REMOVE    = 3'd2,
    OP_MOVE_BACK = 3'd3,
    OP_POP_FRONT = 3'd4
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    LK_NONE     = 2'd0,
    LK_UNLINK   = 2'd1,
    LK_LINK_OWN = 2'd2,
    LK_LINK_NBR = 2'd3
  } link_cmd_e;

  typedef struct packed {
    link_cmd_e         cmd;
    logic [SLOT_W-1:0] slot;
    logic              front;
  } link_req_t;

  typedef struct packed {
    logic [SLOT_W-1:0] head;
    logic [SLOT_W-1:0] tail;
    logic [CNT_W-1:0]  count;
  } link_stat_t;

  typedef struct packed {
    logic              done;
    logic              hit;
    logic [SLOT_W-1:0] hit_slot;
    logic              free_found;
    logic [SLOT_W-1:0] free_slot;
  } search_res_t;

endpackage

### hw/rtl/kose_if.sv
// Valid/ready channel interfaces for operations in and results out.
// Depends on kose_pkg for field widths.
interface kose_in_if;
  logic                         valid;
  logic                         ready;
  logic [kose_pkg::OP_W-1:0]     opcode;
  logic [kose_pkg::KEY_BITS-1:0] key;

  modport source (output valid, output opcode, output key, input ready);
  modport sink (input valid, input opcode, input key, output ready);
endinterface

interface kose_out_if;
  logic                          valid;
  logic                          ready;
  logic [kose_pkg::STATUS_W-1:0] status;
  logic [kose_pkg::KEY_BITS-1:0] key_out;
  logic                          key_hit;
  logic [kose_pkg::CNT_W-1:0]    entry_count;

  modport source (output valid, output status, output key_out, output key_hit,
                  output entry_count, input ready);
  modport sink (input valid, input status, input key_out, input key_hit,
                input entry_count, output ready);
endinterface

### hw/rtl/kose_ram.sv
// Generic single write port RAM with one registered read port.
// No dependencies.
module kose_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                             wdata_i,
  input  logic                                         re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                             rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/kose_search.sv
// Key scan: walks the key memory one slot per cycle through one comparator,
// noting the matching used slot and the lowest free slot. Uses kose_pkg.
module kose_search (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [kose_pkg::KEY_BITS-1:0] key_i,
  input  logic [kose_pkg::CAPACITY-1:0] used_i,
  input  logic [kose_pkg::KEY_BITS-1:0] rdata_i,
  output logic                          re_o,
  output logic [kose_pkg::SLOT_W-1:0]   raddr_o,
  output kose_pkg::search_res_t         res_o
);

  logic [kose_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic                        active_q, active_d;
  logic                        done_q, done_d;
  logic                        hit_q, hit_d;
  logic                        free_q, free_d;
  logic [kose_pkg::SLOT_W-1:0] hit_slot_q, hit_slot_d;
  logic [kose_pkg::SLOT_W-1:0] free_slot_q, free_slot_d;
  logic [kose_pkg::SLOT_W-1:0] cmp_slot;
  logic                        cmp_valid;
  logic                        last;

  // Read data arrives in the cycle after the address: compare the slot issued last.
  assign cmp_slot  = kose_pkg::SLOT_W'(cnt_q - 1'b1);
  assign cmp_valid = active_q && (cnt_q != '0);
  assign last      = (cnt_q == kose_pkg::CNT_W'(kose_pkg::CAPACITY));
  assign re_o      = active_q && !last;
  assign raddr_o   = cnt_q[kose_pkg::SLOT_W-1:0];

  always_comb begin
    cnt_d       = cnt_q;
    active_d    = active_q;
    done_d      = 1'b0;
    hit_d       = hit_q;
    free_d      = free_q;
    hit_slot_d  = hit_slot_q;
    free_slot_d = free_slot_q;
    if (start_i) begin
      cnt_d    = '0;
      active_d = 1'b1;
      hit_d    = 1'b0;
      free_d   = 1'b0;
    end else if (active_q) begin
      if (cmp_valid) begin
        if (used_i[cmp_slot] && (rdata_i == key_i) && !hit_q) begin
          hit_d      = 1'b1;
          hit_slot_d = cmp_slot;
        end
        if (!used_i[cmp_slot] && !free_q) begin
          free_d      = 1'b1;
          free_slot_d = cmp_slot;
        end
      end
      if (last) begin
        active_d = 1'b0;
        done_d   = 1'b1;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      active_q <= 1'b0;
      done_q   <= 1'b0;
      hit_q    <= 1'b0;
      free_q   <= 1'b0;
    end else begin
      cnt_q    <= cnt_d;
      active_q <= active_d;
      done_q   <= done_d;
      hit_q    <= hit_d;
      free_q   <= free_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_slot_q  <= hit_slot_d;
    free_slot_q <= free_slot_d;
  end

  assign res_o.done       = done_q;
  assign res_o.hit        = hit_q;
  assign res_o.hit_slot   = hit_slot_q;
  assign res_o.free_found = free_q;
  assign res_o.free_slot  = free_slot_q;

endmodule

### hw/rtl/kose_links.sv
// Slot chain: previous/next links, head, tail and count, one relink step per
// request. Uses kose_pkg.
module kose_links (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  kose_pkg::link_req_t  req_i,
  output kose_pkg::link_stat_t stat_o
);

  logic [kose_pkg::SLOT_W-1:0] prev_q [kose_pkg::CAPACITY];
  logic [kose_pkg::SLOT_W-1:0] next_q [kose_pkg::CAPACITY];
  logic [kose_pkg::SLOT_W-1:0] head_q, head_d;
  logic [kose_pkg::SLOT_W-1:0] tail_q, tail_d;
  logic [kose_pkg::CNT_W-1:0]  count_q, count_d;

  logic                        prev_we, next_we;
  logic [kose_pkg::SLOT_W-1:0] prev_wa, prev_wd, next_wa, next_wd;
  logic [kose_pkg::SLOT_W-1:0] nb_prev, nb_next;

  assign nb_prev = prev_q[req_i.slot];
  assign nb_next = next_q[req_i.slot];

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    prev_we = 1'b0;
    prev_wa = req_i.slot;
    prev_wd = req_i.slot;
    next_we = 1'b0;
    next_wa = req_i.slot;
    next_wd = req_i.slot;
    unique case (req_i.cmd)
      kose_pkg::LK_UNLINK: begin
        if (req_i.slot == head_q) begin
          head_d = nb_next;
        end else begin
          next_we = 1'b1;
          next_wa = nb_prev;
          next_wd = nb_next;
        end
        if (req_i.slot == tail_q) begin
          tail_d = nb_prev;
        end else begin
          prev_we = 1'b1;
          prev_wa = nb_next;
          prev_wd = nb_prev;
        end
        count_d = count_q - 1'b1;
      end
      kose_pkg::LK_LINK_OWN: begin
        prev_we = 1'b1;
        next_we = 1'b1;
        if (count_q == '0) begin
          head_d = req_i.slot;
          tail_d = req_i.slot;
        end else if (req_i.front) begin
          next_wd = head_q;
        end else begin
          prev_wd = tail_q;
        end
        count_d = count_q + 1'b1;
      end
      kose_pkg::LK_LINK_NBR: begin
        // Hook the old end onto the new slot.
        if (req_i.front) begin
          prev_we = 1'b1;
          prev_wa = head_q;
          head_d  = req_i.slot;
        end else begin
          next_we = 1'b1;
          next_wa = tail_q;
          tail_d  = req_i.slot;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (prev_we) begin
      prev_q[prev_wa] <= prev_wd;
    end
    if (next_we) begin
      next_q[next_wa] <= next_wd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  assign stat_o.head  = head_q;
  assign stat_o.tail  = tail_q;
  assign stat_o.count = count_q;

endmodule

### hw/rtl/keyed_ordered_set_engine.sv
// Keyed ordered set engine: an ordered set of up to CAPACITY distinct keys,
// linked front to back, with add back/front, remove, move to back and pop
// front. One operation is in work at a time; ready is high only between
// operations, while a finished result may still wait in the output register.
// A keyed operation (add, remove, move) runs a key scan that reads one slot
// per cycle from the key memory through the single comparator; up to three
// relink steps follow, then the result step, which waits while the output
// register is still full. Pop front takes an unlink step and the result
// step; pop of an empty set and unused opcodes go straight to the result step.
// Depends on kose_pkg, kose_if, kose_ram, kose_search and kose_links.
module keyed_ordered_set_engine (
  input  logic   clk_i,
  input  logic   rst_ni,
  kose_in_if.sink    in_i,
  kose_out_if.source out_o
);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_SCAN   = 7'b0000010,
    ST_UNLINK = 7'b0000100,
    ST_LINK1  = 7'b0001000,
    ST_LINK2  = 7'b0010000,
    ST_DONE   = 7'b0100000,
    ST_SPARE  = 7'b1000000
  } state_e;

  state_e                         state_q, state_d;
  logic [kose_pkg::OP_W-1:0]      op_q, op_d;
  logic [kose_pkg::KEY_BITS-1:0]  key_q, key_d;
  logic [kose_pkg::SLOT_W-1:0]    slot_q, slot_d;
  logic [kose_pkg::STATUS_W-1:0]  status_q, status_d;
  logic                           hit_q, hit_d;
  logic [kose_pkg::KEY_BITS-1:0]  kout_q, kout_d;
  logic [kose_pkg::CAPACITY-1:0]  used_q, used_d;

  logic                           out_valid_q, out_valid_d;
  logic [kose_pkg::STATUS_W-1:0]  out_status_q, out_status_d;
  logic [kose_pkg::KEY_BITS-1:0]  out_key_q, out_key_d;
  logic                           out_hit_q, out_hit_d;
  logic [kose_pkg::CNT_W-1:0]     out_count_q, out_count_d;

  logic                           accept;
  logic                           search_start;
  logic                           search_re;
  logic [kose_pkg::SLOT_W-1:0]    search_raddr;
  kose_pkg::search_res_t          search_res;
  logic                           pop_re;
  logic                           ram_re;
  logic [kose_pkg::SLOT_W-1:0]    ram_raddr;
  logic                           ram_we;
  logic [kose_pkg::KEY_BITS-1:0]  ram_rdata;
  kose_pkg::link_req_t            link_req;
  kose_pkg::link_stat_t           link_stat;

  assign in_i.ready   = (state_q == ST_IDLE);
  assign accept       = in_i.valid && in_i.ready;
  assign search_start = accept && (in_i.opcode <= kose_pkg::OP_MOVE_BACK);
  assign pop_re       = accept && (in_i.opcode == kose_pkg::OP_POP_FRONT)
                        && (link_stat.count != '0);
  assign ram_re       = search_re || pop_re;
  assign ram_raddr    = search_re ? search_raddr : link_stat.head;

  kose_ram #(
    .WIDTH (kose_pkg::KEY_BITS),
    .DEPTH (kose_pkg::CAPACITY)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (search_res.free_slot),
    .wdata_i (key_q),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  kose_search u_search (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (search_start),
    .key_i   (key_q),
    .used_i  (used_q),
    .rdata_i (ram_rdata),
    .re_o    (search_re),
    .raddr_o (search_raddr),
    .res_o   (search_res)
  );

  kose_links u_links (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (link_req),
    .stat_o (link_stat)
  );

  always_comb begin
    state_d        = state_q;
    op_d           = op_q;
    key_d          = key_q;
    slot_d         = slot_q;
    status_d       = status_q;
    hit_d          = hit_q;
    kout_d         = kout_q;
    used_d         = used_q;
    ram_we         = 1'b0;
    link_req.cmd   = kose_pkg::LK_NONE;
    link_req.slot  = slot_q;
    link_req.front = (op_q == kose_pkg::OP_ADD_FRONT);
    out_valid_d    = out_valid_q && !out_o.ready;
    out_status_d   = out_status_q;
    out_key_d      = out_key_q;
    out_hit_d      = out_hit_q;
    out_count_d    = out_count_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          op_d     = in_i.opcode;
          key_d    = in_i.key;
          hit_d    = 1'b0;
          kout_d   = '0;
          status_d = kose_pkg::STATUS_OK;
          if (in_i.opcode <= kose_pkg::OP_MOVE_BACK) begin
            state_d = ST_SCAN;
          end else if (in_i.opcode == kose_pkg::OP_POP_FRONT) begin
            if (link_stat.count == '0) begin
              status_d = kose_pkg::STATUS_EMPTY;
              state_d  = ST_DONE;
            end else begin
              slot_d  = link_stat.head;
              state_d = ST_UNLINK;
            end
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        if (search_res.done) begin
          hit_d = search_res.hit;
          priority if (search_res.hit) begin
            // Moving the back key to the back changes nothing.
            if ((op_q == kose_pkg::OP_MOVE_BACK) && (search_res.hit_slot == link_stat.tail))
            begin
              state_d = ST_DONE;
            end else begin
              slot_d  = search_res.hit_slot;
              state_d = ST_UNLINK;
            end
          end else if (op_q <= kose_pkg::OP_ADD_FRONT) begin
            if (search_res.free_found) begin
              ram_we                        = 1'b1;
              used_d[search_res.free_slot]  = 1'b1;
              slot_d                        = search_res.free_slot;
              state_d                       = ST_LINK1;
            end else begin
              status_d = kose_pkg::STATUS_FULL;
              state_d  = ST_DONE;
            end
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_UNLINK: begin
        link_req.cmd = kose_pkg::LK_UNLINK;
        if (op_q == kose_pkg::OP_POP_FRONT) begin
          kout_d = ram_rdata;
        end
        if ((op_q == kose_pkg::OP_REMOVE) || (op_q == kose_pkg::OP_POP_FRONT)) begin
          used_d[slot_q] = 1'b0;
          state_d        = ST_DONE;
        end else begin
          state_d = ST_LINK1;
        end
      end
      ST_LINK1: begin
        link_req.cmd = kose_pkg::LK_LINK_OWN;
        // An empty chain needs no neighbor update.
        state_d = (link_stat.count == '0) ? ST_DONE : ST_LINK2;
      end
      ST_LINK2: begin
        link_req.cmd = kose_pkg::LK_LINK_NBR;
        state_d      = ST_DONE;
      end
      ST_DONE: begin
        // Hold until the output register is free.
        if (!out_valid_q || out_o.ready) begin
          out_valid_d  = 1'b1;
          out_status_d = status_q;
          out_key_d    = kout_q;
          out_hit_d    = hit_q;
          out_count_d  = link_stat.count;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    key_q        <= key_d;
    slot_q       <= slot_d;
    status_q     <= status_d;
    hit_q        <= hit_d;
    kout_q       <= kout_d;
    out_status_q <= out_status_d;
    out_key_q    <= out_key_d;
    out_hit_q    <= out_hit_d;
    out_count_q  <= out_count_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = out_status_q;
  assign out_o.key_out     = out_key_q;
  assign out_o.key_hit     = out_hit_q;
  assign out_o.entry_count = out_count_q;

endmodule

### hw/rtl/kose_checker.sv
// Port-level checks of the keyed ordered set engine, bound to the top level.
// Depends on kose_pkg and keyed_ordered_set_engine_macros.svh.
`include "keyed_ordered_set_engine_macros.svh"

module kose_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [kose_pkg::STATUS_W-1:0] status_i,
  input logic [kose_pkg::KEY_BITS-1:0] key_out_i,
  input logic                          key_hit_i,
  input logic [kose_pkg::CNT_W-1:0]    entry_count_i
);

  // One operation at a time: ready drops after every transfer.
  `KOSE_ASSERT_NEXT(a_busy_after_in, in_valid_i && in_ready_i, !in_ready_i)

  `KOSE_ASSERT_SAME(a_count_range, out_valid_i, entry_count_i <= kose_pkg::CAPACITY)

  `KOSE_ASSERT_SAME(a_full_means_full, out_valid_i && (status_i == kose_pkg::STATUS_FULL), (entry_count_i == kose_pkg::CNT_W'(kose_pkg::CAPACITY)) && !key_hit_i)

  `KOSE_ASSERT_SAME(a_empty_pop, out_valid_i && (status_i == kose_pkg::STATUS_EMPTY), (entry_count_i == '0) && (key_out_i == '0) && !key_hit_i)

  `KOSE_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(key_out_i) && $stable(status_i) && $stable(entry_count_i))

endmodule

bind keyed_ordered_set_engine kose_checker u_kose_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .status_i      (out_o.status),
  .key_out_i     (out_o.key_out),
  .key_hit_i     (out_o.key_hit),
  .entry_count_i (out_o.entry_count)
);
